FILE: design/rmsc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the exp2 table for the rms compressor
package rmsc_pkg;

	localparam int SAMPLE_BITS = 24;

	localparam int MS_W     = 2 * SAMPLE_BITS;
	localparam int MS_BASE  = 2 * SAMPLE_BITS - 2;
	localparam int CHUNK_W  = 24;
	localparam int NCHUNK   = (MS_W + CHUNK_W - 1) / CHUNK_W;
	localparam int POS_W    = $clog2(MS_W);
	localparam int NSTEP    = POS_W;
	localparam int LG_W     = POS_W + 16;
	localparam int MUL_W    = (SAMPLE_BITS > 32) ? SAMPLE_BITS : 32;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int CNT_W    = 4;

	localparam int THR_W    = 15;
	localparam int SLOPE_W  = 16;
	localparam int COEF_W   = 24;
	localparam int GAIN_W   = 17;
	localparam int LEVEL_W  = 16;
	localparam int M_W      = 31;
	localparam int G_W      = 31;
	localparam int E_W      = 22;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE  = 3'd4;

	localparam logic [THR_W-1:0]   THR_RESET      = THR_W'(-3840);
	localparam logic [SLOPE_W-1:0] SLOPE_RESET    = SLOPE_W'(-26214);
	localparam logic [COEF_W-1:0]  ATTACK_RESET   = COEF_W'(17459);
	localparam logic [COEF_W-1:0]  RELEASE_RESET  = COEF_W'(17459);
	localparam logic [COEF_W-1:0]  ENVELOPE_RESET = COEF_W'(34913);

	localparam logic [GAIN_W-1:0]  UNITY_GAIN     = GAIN_W'(65536);
	localparam logic [LEVEL_W-1:0] LEVEL_FLOOR    = 16'h8000;
	localparam logic [MUL_W-1:0]   DB_PER_OCT     = MUL_W'(197283);
	localparam logic [MUL_W-1:0]   OCT_PER_DB     = MUL_W'(174165);
	localparam logic [G_W-1:0]     ONE_Q30        = G_W'(1) << 30;
	localparam logic [LG_W-1:0]    LG_BASE        = LG_W'(MS_BASE) << 16;

	typedef logic [15:0][G_W-1:0] pow_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > n) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// entry k is 2^(-2^-(k+1)) in q1.30, each the square root of the one before
	function automatic pow_tab_t build_pow_tab();
		logic [63:0] v;
		pow_tab_t t;
		v = 64'd1 << 29;
		for (int k = 0; k < 16; k++) begin
			v = isqrt64(v << 30);
			t[k] = v[G_W-1:0];
		end
		return t;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

FILE: design/rms_feedforward_compressor.sv
`timescale 1ns / 1ps
// stereo rms feed-forward compressor: sequencer, state and handshakes
// One stereo pair is accepted when the block is idle and worked through by a
// small sequencer around a single shared 32x32 multiplier; a new pair is refused
// (in_stall high) until the sequencer is back in idle. A silent detector skips
// the log2, level and exp2 steps, and a level at or below the threshold skips
// the exp2 steps. When compressing the multiplier does two squares, NCHUNK
// products for each of the two one-pole updates, 16 squarings for the log2
// fraction, one product each for the dB level, the slope and the exponent, 16
// products for the exp2 gain and two output scalings. The result sits in an
// output register, so the next pair may be taken while it waits on out_stall.
// The configuration port is always ready; writes are meant for idle time only.
// Reset clears the detector to zero and the applied gain to unity.
module rms_feedforward_compressor (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [rmsc_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [rmsc_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [rmsc_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [rmsc_pkg::SAMPLE_BITS-1:0] right_out,
	output logic        [rmsc_pkg::GAIN_W-1:0]      gain_now,
	output logic signed [rmsc_pkg::LEVEL_W-1:0]     level_db,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic        [rmsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [rmsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rmsc_pkg::*;

	localparam int SB = SAMPLE_BITS;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_SQL      = 5'd1;
	localparam logic [4:0] S_SQR      = 5'd2;
	localparam logic [4:0] S_SUMX     = 5'd3;
	localparam logic [4:0] S_MSDIFF   = 5'd4;
	localparam logic [4:0] S_APMUL    = 5'd5;
	localparam logic [4:0] S_APACC    = 5'd6;
	localparam logic [4:0] S_APDONE   = 5'd7;
	localparam logic [4:0] S_NZ       = 5'd8;
	localparam logic [4:0] S_NORM     = 5'd9;
	localparam logic [4:0] S_LOGINIT  = 5'd10;
	localparam logic [4:0] S_LSQ      = 5'd11;
	localparam logic [4:0] S_LSTEP    = 5'd12;
	localparam logic [4:0] S_DBMUL    = 5'd13;
	localparam logic [4:0] S_DB       = 5'd14;
	localparam logic [4:0] S_CMP      = 5'd15;
	localparam logic [4:0] S_EMUL     = 5'd16;
	localparam logic [4:0] S_EROUND   = 5'd17;
	localparam logic [4:0] S_EXP      = 5'd18;
	localparam logic [4:0] S_EXPW     = 5'd19;
	localparam logic [4:0] S_EFIN     = 5'd20;
	localparam logic [4:0] S_GAINDIFF = 5'd21;
	localparam logic [4:0] S_OUTL     = 5'd22;
	localparam logic [4:0] S_OUTR     = 5'd23;
	localparam logic [4:0] S_OUTR2    = 5'd24;

	// configuration registers
	logic [THR_W-1:0]   thr_q;
	logic [SLOPE_W-1:0] slope_q;
	logic [COEF_W-1:0]  attack_q;
	logic [COEF_W-1:0]  release_q;
	logic [COEF_W-1:0]  env_q;

	// sequencer and block state
	logic [4:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MS_W-1:0]   ms_q;
	logic [GAIN_W-1:0] gain_q;

	// per-pair working registers
	logic [SB-1:0]      l_q;
	logic [SB-1:0]      al_q;
	logic [SB-1:0]      ar_q;
	logic [MS_W-1:0]    x_q;
	logic [MS_W-1:0]    ap_a_q;
	logic [MS_W-1:0]    acc_q;
	logic [COEF_W-1:0]  ap_c_q;
	logic               ap_up_q;
	logic               ap_sel_q;
	logic [MS_W-1:0]    norm_q;
	logic [POS_W-1:0]   pos_q;
	logic [M_W-1:0]     m_q;
	logic [15:0]        frac_q;
	logic [LEVEL_W-1:0] level_q;
	logic [E_W-1:0]     e_q;
	logic [G_W-1:0]     g_q;
	logic [GAIN_W-1:0]  target_q;
	logic [SB-1:0]      left_res_q;
	logic               r_neg_q;

	// output register
	logic               out_valid_q;
	logic [SB-1:0]      left_out_q;
	logic [SB-1:0]      right_out_q;
	logic [GAIN_W-1:0]  gain_out_q;
	logic [LEVEL_W-1:0] level_out_q;

	// multiplier
	logic              mul_en;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;

	// combinational helpers
	logic [NCHUNK*CHUNK_W-1:0] ap_ext;
	logic [CHUNK_W-1:0]        chunk;
	logic [MS_W:0]             x_sum;
	logic [MS_W-1:0]           ap_cur;
	logic [MS_W-1:0]           ap_res;
	logic [POS_W-1:0]          norm_sh;
	logic [MS_W-1:0]           norm_mask;
	logic                      top_zero;
	logic [MS_W+31:0]          norm_ext;
	logic [31:0]               sq_t;
	logic [LG_W-1:0]           lg;
	logic [LG_W-1:0]           mag;
	logic [47:0]               db_r;
	logic [23:0]               db;
	logic signed [16:0]        lvl_diff;
	logic                      compress;
	logic [SLOPE_W-1:0]        nslope;
	logic [15:0]               e_frac;
	logic [5:0]                e_oct;
	logic [G_W-1:0]            g_sh;
	logic [G_W-1:0]            g_rnd;
	logic [GAIN_W-1:0]         exp_gain;
	logic [SB+15:0]            scale_r;
	logic [SB-1:0]             scale_mag;
	logic                      out_go;
	logic                      in_acc;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_go    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign gain_now  = gain_out_q;
	assign level_db  = level_out_q;

	rmsc_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// one-pole update: chunk of |target - cur| times coefficient, top chunk first
	assign ap_ext = (NCHUNK*CHUNK_W)'(ap_a_q);
	assign chunk  = ap_ext[CHUNK_W*cnt_q +: CHUNK_W];
	assign ap_cur = ap_sel_q ? MS_W'(gain_q) : ms_q;
	assign ap_res = ap_up_q ? (ap_cur + acc_q) : (ap_cur - acc_q);
	assign x_sum  = {1'b0, x_q} + {1'b0, prod[MS_W-1:0]};

	// leading-one search, halving the shift each step
	assign norm_sh   = POS_W'(1) << (POS_W'(NSTEP - 1) - POS_W'(cnt_q));
	assign norm_mask = ~({MS_W{1'b1}} >> norm_sh);
	assign top_zero  = ((norm_q & norm_mask) == '0);
	assign norm_ext  = {norm_q, 32'd0};

	// log2 fraction by repeated squaring of the q1.30 mantissa
	assign sq_t = prod[61:30];
	assign lg   = {pos_q, frac_q};
	assign mag  = (lg >= LG_BASE) ? '0 : (LG_BASE - lg);
	assign db_r = prod[47:0] + 48'h800000;
	assign db   = db_r[47:24];

	// compress only above threshold with a downward slope
	assign lvl_diff = {level_q[LEVEL_W-1], level_q} - {{2{thr_q[THR_W-1]}}, thr_q};
	assign compress = !lvl_diff[16] && (lvl_diff != '0) && slope_q[SLOPE_W-1];
	assign nslope   = ~slope_q + 1'b1;

	// exp2 of the negative exponent: fraction by table products, octaves by shift
	assign e_frac   = e_q[15:0];
	assign e_oct    = e_q[21:16];
	assign g_sh     = g_q >> e_oct[4:0];
	assign g_rnd    = g_sh + G_W'(1 << 13);
	assign exp_gain = (e_oct >= 6'd31) ? '0 : GAIN_W'(g_rnd >> 14);

	// output scaling, rounded half away from zero on the magnitude
	assign scale_r   = prod[SB+15:0] + (SB+16)'(32768);
	assign scale_mag = scale_r[SB+15:16];

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_SQL: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(al_q);
				mul_b  = MUL_W'(al_q);
			end
			S_SQR: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(ar_q);
				mul_b  = MUL_W'(ar_q);
			end
			S_APMUL: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(chunk);
				mul_b  = MUL_W'(ap_c_q);
			end
			S_LSQ: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(m_q);
				mul_b  = MUL_W'(m_q);
			end
			S_DBMUL: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(mag);
				mul_b  = DB_PER_OCT;
			end
			S_CMP: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(lvl_diff[15:0]);
				mul_b  = MUL_W'(nslope);
			end
			S_EMUL: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(prod[30:0]);
				mul_b  = OCT_PER_DB;
			end
			S_EXP: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(g_q);
				mul_b  = e_frac[4'd15 - cnt_q] ? MUL_W'(POW_TAB[cnt_q]) : MUL_W'(ONE_Q30);
			end
			S_OUTL: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(al_q);
				mul_b  = MUL_W'(gain_q);
			end
			S_OUTR: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(ar_q);
				mul_b  = MUL_W'(gain_q);
			end
			default: ;
		endcase
	end

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THR_RESET;
			slope_q   <= SLOPE_RESET;
			attack_q  <= ATTACK_RESET;
			release_q <= RELEASE_RESET;
			env_q     <= ENVELOPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				REG_SLOPE:     slope_q   <= cfg_data[SLOPE_W-1:0];
				REG_ATTACK:    attack_q  <= cfg_data[COEF_W-1:0];
				REG_RELEASE:   release_q <= cfg_data[COEF_W-1:0];
				REG_ENVELOPE:  env_q     <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and the two pieces of lasting state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ms_q    <= '0;
			gain_q  <= UNITY_GAIN;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_SQL;
				end
				S_SQL:    state_q <= S_SQR;
				S_SQR:    state_q <= S_SUMX;
				S_SUMX:   state_q <= S_MSDIFF;
				S_MSDIFF: begin
					cnt_q   <= CNT_W'(NCHUNK - 1);
					state_q <= S_APMUL;
				end
				S_APMUL:  state_q <= S_APACC;
				S_APACC: begin
					if (cnt_q != '0) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_APMUL;
					end else begin
						state_q <= S_APDONE;
					end
				end
				S_APDONE: begin
					if (ap_sel_q) begin
						gain_q  <= ap_res[GAIN_W-1:0];
						state_q <= S_OUTL;
					end else begin
						ms_q    <= ap_res;
						state_q <= S_NZ;
					end
				end
				S_NZ: begin
					cnt_q   <= '0;
					state_q <= (ms_q == '0) ? S_GAINDIFF : S_NORM;
				end
				S_NORM: begin
					if (cnt_q == CNT_W'(NSTEP - 1)) begin
						cnt_q   <= '0;
						state_q <= S_LOGINIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_LOGINIT: state_q <= S_LSQ;
				S_LSQ:     state_q <= S_LSTEP;
				S_LSTEP: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= (cnt_q == 4'd15) ? S_DBMUL : S_LSQ;
				end
				S_DBMUL:  state_q <= S_DB;
				S_DB:     state_q <= S_CMP;
				S_CMP:    state_q <= compress ? S_EMUL : S_GAINDIFF;
				S_EMUL:   state_q <= S_EROUND;
				S_EROUND: begin
					cnt_q   <= '0;
					state_q <= S_EXP;
				end
				S_EXP:    state_q <= S_EXPW;
				S_EXPW: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= (cnt_q == 4'd15) ? S_EFIN : S_EXP;
				end
				S_EFIN:   state_q <= S_GAINDIFF;
				S_GAINDIFF: begin
					cnt_q   <= CNT_W'(NCHUNK - 1);
					state_q <= S_APMUL;
				end
				S_OUTL:   state_q <= S_OUTR;
				S_OUTR:   state_q <= S_OUTR2;
				S_OUTR2: begin
					if (out_go) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// working datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					l_q     <= left_in;
					r_neg_q <= right_in[SB-1];
					al_q    <= left_in[SB-1] ? (~left_in + 1'b1) : left_in;
					ar_q    <= right_in[SB-1] ? (~right_in + 1'b1) : right_in;
				end
			end
			S_SQR:  x_q <= prod[MS_W-1:0];
			S_SUMX: x_q <= x_sum[MS_W:1];
			S_MSDIFF: begin
				ap_up_q  <= (x_q >= ms_q);
				ap_a_q   <= (x_q >= ms_q) ? (x_q - ms_q) : (ms_q - x_q);
				ap_c_q   <= env_q;
				ap_sel_q <= 1'b0;
				acc_q    <= '0;
			end
			S_APACC: begin
				if (cnt_q != '0) acc_q <= (acc_q << CHUNK_W) + prod[MS_W-1:0];
				else             acc_q <= acc_q + MS_W'(prod >> CHUNK_W);
			end
			S_NZ: begin
				norm_q <= ms_q;
				pos_q  <= POS_W'(MS_W - 1);
				if (ms_q == '0) begin
					level_q  <= LEVEL_FLOOR;
					target_q <= UNITY_GAIN;
				end
			end
			S_NORM: begin
				if (top_zero) begin
					norm_q <= norm_q << norm_sh;
					pos_q  <= pos_q - norm_sh;
				end
			end
			S_LOGINIT: begin
				m_q    <= norm_ext[MS_W+31 -: M_W];
				frac_q <= '0;
			end
			S_LSTEP: begin
				frac_q <= {frac_q[14:0], sq_t[31]};
				m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
			end
			S_DB: begin
				if (db > 24'd32768) level_q <= LEVEL_FLOOR;
				else                level_q <= 16'd0 - db[15:0];
			end
			S_CMP: begin
				if (!compress) target_q <= UNITY_GAIN;
			end
			S_EROUND: begin
				e_q <= E_W'((prod + PROD_W'(64'h4000000)) >> 27);
				g_q <= ONE_Q30;
			end
			S_EXPW: g_q <= prod[G_W+29:30];
			S_EFIN: target_q <= (exp_gain > UNITY_GAIN) ? UNITY_GAIN : exp_gain;
			S_GAINDIFF: begin
				ap_up_q  <= (target_q >= gain_q);
				ap_a_q   <= MS_W'((target_q >= gain_q) ? (target_q - gain_q)
				                                       : (gain_q - target_q));
				ap_c_q   <= (target_q <= gain_q) ? attack_q : release_q;
				ap_sel_q <= 1'b1;
				acc_q    <= '0;
			end
			S_OUTR: left_res_q <= l_q[SB-1] ? (~scale_mag + 1'b1) : scale_mag;
			default: ;
		endcase
	end

	// output register, refilled once the previous beat is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUTR2 && out_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUTR2 && out_go) begin
			left_out_q  <= left_res_q;
			right_out_q <= r_neg_q ? (~scale_mag + 1'b1) : scale_mag;
			gain_out_q  <= gain_q;
			level_out_q <= level_q;
		end
	end

	ap_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("pair accepted but sequencer did not leave idle");

	ap_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY_GAIN)
		else $error("smoothed gain above unity");

	ap_level_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (level_out_q[LEVEL_W-1] || level_out_q == '0))
		else $error("reported level above full scale");

	ap_ms_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_APDONE) |=> $stable(ms_q))
		else $error("mean square changed outside its update step");

	ap_gain_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_APDONE) |=> $stable(gain_q))
		else $error("gain changed outside its update step");

endmodule

FILE: design/rmsc_mul.sv
`timescale 1ns / 1ps
// shared unsigned multiplier with registered product
module rmsc_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rmsc_pkg::MUL_W-1:0]    a,
	input  logic [rmsc_pkg::MUL_W-1:0]    b,
	output logic [rmsc_pkg::PROD_W-1:0]   p_q
);
	import rmsc_pkg::*;

	always_ff @(posedge clk) begin
		if (en) p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the stereo rms feed-forward compressor
module testbench;
	import rmsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int TAIL_CYCLES    = 150;

	// one expected output beat
	typedef struct {
		logic signed [SAMPLE_BITS-1:0] left_s;
		logic signed [SAMPLE_BITS-1:0] right_s;
		logic        [GAIN_W-1:0]      gain;
		logic signed [LEVEL_W-1:0]     level;
	} comp_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_BITS-1:0] left_in = '0;
	logic signed [SAMPLE_BITS-1:0] right_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic [GAIN_W-1:0] gain_now;
	logic signed [LEVEL_W-1:0] level_db;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the register file
	logic signed [THR_W-1:0]   thr_shadow;
	logic signed [SLOPE_W-1:0] slope_shadow;
	logic [COEF_W-1:0]         attack_shadow;
	logic [COEF_W-1:0]         release_shadow;
	logic [COEF_W-1:0]         env_shadow;

	// predicted detector and gain state
	logic [63:0] ms_model;
	logic [63:0] gain_model;
	logic [63:0] root_tab [16];

	comp_frame_t frames_due [$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	rms_feedforward_compressor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_out(left_out), .right_out(right_out),
		.gain_now(gain_now), .level_db(level_db),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic logic [63:0] int_sqrt(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n_in;
		r = '0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// floor(a * c / 2^24), split so the product stays inside 64 bits
	function automatic logic [63:0] scale_q24(input logic [63:0] a, input logic [63:0] c);
		return (a >> 24) * c + (((a & 64'hFF_FFFF) * c) >> 24);
	endfunction

	// one-pole step of cur toward target
	function automatic logic [63:0] glide(input logic [63:0] cur, input logic [63:0] target,
			input logic [63:0] c);
		if (target >= cur) begin
			return cur + scale_q24(target - cur, c);
		end
		return cur - scale_q24(cur - target, c);
	endfunction

	// log2 with 16 fraction bits by repeated squaring of the normalized mantissa
	function automatic logic [63:0] log2_frac16(input logic [63:0] v);
		int p;
		logic [63:0] m;
		logic [63:0] frac;
		p = 63;
		frac = '0;
		while (v[p] == 1'b0) p--;
		m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		return (64'(p) << 16) + frac;
	endfunction

	// 2^(-e/65536) in q1.16
	function automatic logic [63:0] pow2_neg(input logic [63:0] e);
		logic [63:0] octaves;
		logic [63:0] g;
		octaves = e >> 16;
		g = 64'd1 << 30;
		for (int k = 0; k < 16; k++) begin
			if (e[15-k]) g = (g * root_tab[k]) >> 30;
		end
		if (octaves >= 31) return 64'd0;
		g = g >> octaves;
		return (g + (64'd1 << 13)) >> 14;
	endfunction

	task automatic predict_pair(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r);
		longint li;
		longint ri;
		longint lvl;
		longint thr;
		longint slp;
		longint prod;
		logic [63:0] al;
		logic [63:0] ar;
		logic [63:0] sq;
		logic [63:0] lg;
		logic [63:0] mag;
		logic [63:0] db;
		logic [63:0] e;
		logic [63:0] tgt;
		logic [63:0] c;
		logic [63:0] ml;
		logic [63:0] mr;
		comp_frame_t f;
		li = l;
		ri = r;
		al = (li < 0) ? -li : li;
		ar = (ri < 0) ? -ri : ri;
		thr = thr_shadow;
		slp = slope_shadow;
		sq = (al * al + ar * ar) >> 1;
		ms_model = glide(ms_model, sq, env_shadow);
		tgt = 64'(UNITY_GAIN);
		// silent detector sits on the floor
		if (ms_model == 0) begin
			lvl = -32768;
		end else begin
			lg = log2_frac16(ms_model);
			mag = (lg >= (64'(MS_BASE) << 16)) ? 64'd0 : (64'(MS_BASE) << 16) - lg;
			db = (mag * 64'd197283 + (64'd1 << 23)) >> 24;
			if (db > 64'd32768) db = 64'd32768;
			lvl = -longint'(db);
		end
		if (ms_model != 0 && lvl > thr) begin
			prod = (lvl - thr) * slp;
			// a positive product (positive slope) leaves the target at unity
			if (prod < 0) begin
				e = (64'(-prod) * 64'd174165 + (64'd1 << 26)) >> 27;
				tgt = pow2_neg(e);
			end
		end
		if (tgt > 64'(UNITY_GAIN)) tgt = 64'(UNITY_GAIN);
		c = (tgt <= gain_model) ? 64'(attack_shadow) : 64'(release_shadow);
		gain_model = glide(gain_model, tgt, c) & 64'h1_FFFF;
		ml = (al * gain_model + 64'd32768) >> 16;
		mr = (ar * gain_model + 64'd32768) >> 16;
		f.left_s = (li < 0) ? SAMPLE_BITS'(-ml) : SAMPLE_BITS'(ml);
		f.right_s = (ri < 0) ? SAMPLE_BITS'(-mr) : SAMPLE_BITS'(mr);
		f.gain = GAIN_W'(gain_model);
		f.level = LEVEL_W'(lvl);
		frames_due.push_back(f);
	endtask

	// ---------------- drivers ----------------

	// sends one stereo beat after a random idle gap, leaves valid high
	task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		do @(posedge clk); while (in_stall);
		predict_pair(l, r);
	endtask

	// wait until every expected beat is out and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one register write, then cfg_valid is dropped with the channel left idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_shadow = THR_W'(value);
			REG_SLOPE:     slope_shadow = SLOPE_W'(value);
			REG_ATTACK:    attack_shadow = COEF_W'(value);
			REG_RELEASE:   release_shadow = COEF_W'(value);
			REG_ENVELOPE:  env_shadow = COEF_W'(value);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input longint thr, input longint slp, input longint atk,
			input longint rel, input longint env);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_SLOPE, slp);
		write_reg(REG_ATTACK, atk);
		write_reg(REG_RELEASE, rel);
		write_reg(REG_ENVELOPE, env);
	endtask

	// ---------------- receiver side ----------------

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// output checker: compare each accepted beat with the oldest prediction
	always @(posedge clk) begin
		comp_frame_t f;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected output beat left %0d right %0d", $time,
					left_out, right_out);
				errors++;
			end else begin
				f = frames_due.pop_front();
				if (left_out !== f.left_s) begin
					$display("%0t: left_out expected %0d actual %0d", $time, f.left_s, left_out);
					errors++;
				end
				if (right_out !== f.right_s) begin
					$display("%0t: right_out expected %0d actual %0d", $time, f.right_s,
						right_out);
					errors++;
				end
				if (gain_now !== f.gain) begin
					$display("%0t: gain_now expected %0d actual %0d", $time, f.gain, gain_now);
					errors++;
				end
				if (level_db !== f.level) begin
					$display("%0t: level_db expected %0d actual %0d", $time, f.level, level_db);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------- tests ----------------

	// reset values: silence first, then loud pairs against the default threshold, then silence
	task automatic test_reset_defaults();
		send_pair(0, 0);
		send_pair(-8388608, -8388608);
		send_pair(8388607, 8388607);
		send_pair(-8388608, 8388607);
		send_pair(0, 0);
		drain();
	endtask

	// tiny levels fall under the -256 dB floor, fast detector tracks them
	task automatic test_low_level_floor();
		write_reg(REG_ENVELOPE, 16777215);
		send_pair(1, 0);
		send_pair(0, -1);
		send_pair(1, -1);
		send_pair(255, -256);
		send_pair(0, 0);
		drain();
	endtask

	// register extremes, including a positive slope and unknown indexes
	task automatic test_register_extremes();
		write_all(-12800, -31130, 16777215, 0, 16777215);
		send_pair(8388607, -8388608);
		send_pair(4194304, -4194304);
		send_pair(1000, 1000);
		drain();
		write_all(0, 0, 0, 16777215, 0);
		send_pair(-8388608, -8388608);
		send_pair(12345, -54321);
		drain();
		// positive slope never compresses, so the target stays at unity
		write_all(-16384, 32767, 8388608, 8388608, 16777215);
		send_pair(8388607, 8388607);
		send_pair(-3000000, 2000000);
		drain();
		write_reg(3'd5, 24'hFFFFFF);
		write_reg(3'd6, 0);
		write_reg(3'd7, 24'hA5A5A5);
		// full-scale negative slope code and loud material
		write_all(-16384, -32768, 16777215, 16777215, 16777215);
		send_pair(8388607, -8388608);
		send_pair(-8388608, 8388607);
		send_pair(6000000, 6000000);
		drain();
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int kind;
		logic signed [SAMPLE_BITS-1:0] s;
		kind = $urandom_range(99);
		s = SAMPLE_BITS'($urandom);
		if (kind < 35) return s;
		if (kind < 70) return s >>> $urandom_range(SAMPLE_BITS - 1);
		if (kind < 80) return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
		if (kind < 90) return 0;
		return SAMPLE_BITS'($urandom_range(3)) - 2;
	endfunction

	function automatic longint pick_coeff();
		case ($urandom_range(3))
			0: return $urandom_range(16777215);
			1: return $urandom_range(65535);
			2: return $urandom_range(1) ? 16777215 : 0;
			default: return 64'd1 << $urandom_range(23);
		endcase
	endfunction

	// random bursts: loud sections, quiet tails, mixed steady tones
	task automatic test_random_traffic(input int in_idle, input int out_busy, input int n);
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
		int shift;
		write_all(-longint'($urandom_range(12800)), -longint'($urandom_range(31130)),
			pick_coeff(), pick_coeff(), pick_coeff());
		idle_pct = in_idle;
		stall_pct = out_busy;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				l = pick_sample();
				r = pick_sample();
			end else begin
				// held level with random sign and jitter, the usual compressor case
				shift = (i / 16) % 12;
				l = (SAMPLE_BITS'($urandom_range(8388607)) >>> shift);
				r = (SAMPLE_BITS'($urandom_range(8388607)) >>> shift);
				if ($urandom_range(1)) l = -l;
				if ($urandom_range(1)) r = -r;
			end
			send_pair(l, r);
		end
		drain();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		thr_shadow = THR_RESET;
		slope_shadow = SLOPE_RESET;
		attack_shadow = ATTACK_RESET;
		release_shadow = RELEASE_RESET;
		env_shadow = ENVELOPE_RESET;
		ms_model = '0;
		gain_model = 64'(UNITY_GAIN);
		begin
			logic [63:0] v;
			v = 64'd1 << 29;
			for (int k = 0; k < 16; k++) begin
				v = int_sqrt(v << 30);
				root_tab[k] = v;
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_low_level_floor();
		test_register_extremes();
		test_random_traffic(0, 0, 280);
		test_random_traffic(80, 0, 270);
		test_random_traffic(0, 80, 270);
		test_random_traffic(8, 8, 260);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && frames_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/rmsc_pkg.sv
design/rmsc_mul.sv
design/rms_feedforward_compressor.sv
tb/testbench.sv
